/* rtl/core/sbgd_pkg.sv */
// Shared types and constants for the single-button gesture decoder.
package sbgd_pkg;

   localparam int unsigned TimeW = 16;

   localparam logic [TimeW-1:0] TIME_SAT = {TimeW{1'b1}};

   // Register reset values
   localparam logic [TimeW-1:0] DEBOUNCE_RST     = 16'd75;
   localparam logic [TimeW-1:0] SELECT_HOLD_RST  = 16'd550;
   localparam logic [TimeW-1:0] BACK_HOLD_RST    = 16'd1200;
   localparam logic [TimeW-1:0] DOUBLE_CLICK_RST = 16'd300;

   localparam logic [1:0] TALLY_MAX = 2'd3;
   localparam logic [1:0] TALLY_DOUBLE = 2'd2;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE     = 2'd0,
      CSR_SELECT_HOLD  = 2'd1,
      CSR_BACK_HOLD    = 2'd2,
      CSR_DOUBLE_CLICK = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      IND_NONE   = 2'd0,
      IND_SELECT = 2'd1,
      IND_ESCAPE = 2'd2
   } indicator_type;

   typedef struct packed {
      logic [TimeW-1:0] debounce_ms;
      logic [TimeW-1:0] select_hold_ms;
      logic [TimeW-1:0] back_hold_ms;
      logic [TimeW-1:0] double_click_ms;
   } cfg_type;

   typedef struct packed {
      logic             was_down;
      logic [TimeW-1:0] since_press;
      logic [TimeW-1:0] since_release;
      logic [1:0]       click_tally;
      logic             next_pending;
      logic             long_flag;
      indicator_type    indicator_level;
   } state_type;

   localparam state_type STATE_RST = '{
      was_down:        1'b0,
      since_press:     TIME_SAT,
      since_release:   TIME_SAT,
      click_tally:     2'd0,
      next_pending:    1'b0,
      long_flag:       1'b0,
      indicator_level: IND_NONE
   };

   typedef struct packed {
      logic          next_press;
      logic          prev_press;
      logic          select_press;
      logic          escape_press;
      logic          any_key;
      logic          long_held;
      indicator_type hold_indicator;
   } result_type;

endpackage

/* rtl/core/sbgd_cfg.sv */
// Timing register file for the gesture decoder.
module sbgd_cfg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   output sbgd_pkg::cfg_type    cfg_o
);
   import sbgd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:     cfg_in.debounce_ms     = csr_wdata;
            CSR_SELECT_HOLD:  cfg_in.select_hold_ms  = csr_wdata;
            CSR_BACK_HOLD:    cfg_in.back_hold_ms    = csr_wdata;
            CSR_DOUBLE_CLICK: cfg_in.double_click_ms = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{DEBOUNCE_RST, SELECT_HOLD_RST, BACK_HOLD_RST, DOUBLE_CLICK_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

/* rtl/core/sbgd_step.sv */
// One-tick next-state and result logic of the gesture decoder.
module sbgd_step (
   input  logic                  button_down,
   input  sbgd_pkg::cfg_type     cfg_i,
   input  sbgd_pkg::state_type   state_i,
   output sbgd_pkg::state_type   state_o,
   output sbgd_pkg::result_type  result_o
);
   import sbgd_pkg::*;

   state_type  st;
   result_type res;
   logic       debounced;

   always_comb begin
      st  = state_i;
      res = '0;
      // elapsed counters, saturating
      st.since_press   = (state_i.since_press == TIME_SAT) ? TIME_SAT
                                                           : state_i.since_press + 16'd1;
      st.since_release = (state_i.since_release == TIME_SAT) ? TIME_SAT
                                                             : state_i.since_release + 16'd1;
      debounced = (st.since_press < cfg_i.debounce_ms) && !state_i.long_flag;

      if (!debounced) begin
         if (st.next_pending && (st.since_release > cfg_i.double_click_ms)) begin
            res.next_press  = 1'b1;
            st.next_pending = 1'b0;
         end

         if (button_down) begin
            if (!st.was_down) begin
               st.was_down    = 1'b1;
               st.since_press = '0;
               st.long_flag   = 1'b0;
            end
            res.any_key = 1'b1;
            if (st.since_press >= cfg_i.select_hold_ms) begin
               st.long_flag = 1'b1;
               if (st.indicator_level < IND_SELECT) begin
                  st.indicator_level = IND_SELECT;
               end
            end
            if (st.since_press >= cfg_i.back_hold_ms) begin
               st.indicator_level = IND_ESCAPE;
            end
         end else if (st.was_down) begin
            st.was_down        = 1'b0;
            st.indicator_level = IND_NONE;
            if (st.since_release > cfg_i.double_click_ms) begin
               st.click_tally = '0;
            end
            if (st.since_press >= cfg_i.back_hold_ms) begin
               res.escape_press = 1'b1;
               st.next_pending  = 1'b0;
            end else if (st.since_press >= cfg_i.select_hold_ms) begin
               res.select_press = 1'b1;
               st.next_pending  = 1'b0;
            end else begin
               // short click
               if (st.click_tally != TALLY_MAX) begin
                  st.click_tally = st.click_tally + 2'd1;
               end
               st.since_release = '0;
               if (st.click_tally >= TALLY_DOUBLE) begin
                  res.prev_press  = 1'b1;
                  st.click_tally  = '0;
                  st.next_pending = 1'b0;
               end else begin
                  st.next_pending = 1'b1;
               end
            end
            res.any_key  = 1'b1;
            st.long_flag = 1'b0;
         end
      end

      res.long_held      = st.long_flag;
      res.hold_indicator = st.indicator_level;
   end

   assign state_o  = st;
   assign result_o = res;

endmodule

/* rtl/core/single_button_gesture_decoder.sv */
// Top level of the single-button gesture decoder: beat registers and state.
// A request beat is held in the input register; its result is captured in the response register.
// Throughput: one tick per cycle while the response channel is not stalled; the input register,
//   the state update and the response register form a two-deep pipeline with full back-pressure.
// The combinational path is the 16-bit saturating increments and compares in sbgd_step.
// Reset (synchronous, active high) loads the timing registers with their defaults,
//   sets both elapsed counters to saturated and clears all other state and both beats.
module single_button_gesture_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel: one millisecond tick
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_button_down,
   // response channel: gesture result for that tick
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_next_press,
   output logic        rsp_prev_press,
   output logic        rsp_select_press,
   output logic        rsp_escape_press,
   output logic        rsp_any_key,
   output logic        rsp_long_held,
   output logic [1:0]  rsp_hold_indicator,
   // timing registers, write only
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import sbgd_pkg::*;

   cfg_type    cfg;

   // input stage
   logic       in_valid_ff;
   logic       in_down_ff;
   logic       advance;

   // decoder state
   state_type  state_ff;
   state_type  state_in;

   // response stage
   result_type result_in;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;

   sbgd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_o     (cfg)
   );

   sbgd_step u_step (
      .button_down (in_down_ff),
      .cfg_i       (cfg),
      .state_i     (state_ff),
      .state_o     (state_in),
      .result_o    (result_in)
   );

   // The held tick moves on whenever the response register is free or being drained;
   // the input register takes a new beat in that same cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_down_ff <= req_button_down;
      end
   end

   // state commits only when the tick's result is captured
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RST;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_press     = rsp_data_ff.next_press;
   assign rsp_prev_press     = rsp_data_ff.prev_press;
   assign rsp_select_press   = rsp_data_ff.select_press;
   assign rsp_escape_press   = rsp_data_ff.escape_press;
   assign rsp_any_key        = rsp_data_ff.any_key;
   assign rsp_long_held      = rsp_data_ff.long_held;
   assign rsp_hold_indicator = rsp_data_ff.hold_indicator;

   // Release outcomes are mutually exclusive.
   a_release_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.prev_press, rsp_data_ff.select_press,
                                 rsp_data_ff.escape_press}))
      else $error("more than one release outcome in one beat");

   // Every release outcome is a release tick, so any_key must be set.
   a_release_any: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.prev_press || rsp_data_ff.select_press ||
                       rsp_data_ff.escape_press) |-> rsp_data_ff.any_key)
      else $error("release outcome without any_key");

   // Indicator never takes the unused code.
   a_indicator_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.indicator_level != 2'd3)
      else $error("indicator level out of range");

   // A held tick that cannot move stays in the input register.
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_down_ff))
      else $error("held tick lost while stalled");

   // State only changes when a tick is processed.
   a_state_commit: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("decoder state changed without a tick");

endmodule

/* verif/gesture_check.sv */
// Gesture decoder checker: watches both beat channels, predicts each tick and compares.
`timescale 1ns / 100ps

module gesture_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_button_down,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_next_press,
   input  logic        rsp_prev_press,
   input  logic        rsp_select_press,
   input  logic        rsp_escape_press,
   input  logic        rsp_any_key,
   input  logic        rsp_long_held,
   input  logic [1:0]  rsp_hold_indicator,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   import sbgd_pkg::*;

   cfg_type    timing;
   state_type  btn;
   result_type owed_gestures[$];
   int         mismatch_count = 0;
   int         beats_owed = 0;

   assign fail_count = mismatch_count;
   assign pending    = beats_owed;

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got_v, want_v);
      mismatch_count++;
   endtask

   // one millisecond tick of the button decoder; updates btn, returns the gesture beat
   function automatic result_type decode_tick(input logic down);
      result_type       gest;
      logic [TimeW-1:0] held;
      gest = '0;
      if (btn.since_press != TIME_SAT) btn.since_press = btn.since_press + 16'd1;
      if (btn.since_release != TIME_SAT) btn.since_release = btn.since_release + 16'd1;
      if (btn.since_press >= timing.debounce_ms || btn.long_flag) begin
         if (btn.next_pending && btn.since_release > timing.double_click_ms) begin
            gest.next_press  = 1'b1;
            btn.next_pending = 1'b0;
         end
         if (down) begin
            if (!btn.was_down) begin
               btn.was_down    = 1'b1;
               btn.since_press = '0;
               btn.long_flag   = 1'b0;
            end
            gest.any_key = 1'b1;
            if (btn.since_press >= timing.select_hold_ms) begin
               btn.long_flag = 1'b1;
               if (btn.indicator_level == IND_NONE) btn.indicator_level = IND_SELECT;
            end
            if (btn.since_press >= timing.back_hold_ms) btn.indicator_level = IND_ESCAPE;
         end else if (btn.was_down) begin
            held                = btn.since_press;
            btn.was_down        = 1'b0;
            btn.indicator_level = IND_NONE;
            if (btn.since_release > timing.double_click_ms) btn.click_tally = '0;
            if (held >= timing.back_hold_ms) begin
               gest.escape_press = 1'b1;
               btn.next_pending  = 1'b0;
            end else if (held >= timing.select_hold_ms) begin
               gest.select_press = 1'b1;
               btn.next_pending  = 1'b0;
            end else begin
               if (btn.click_tally < TALLY_MAX) btn.click_tally = btn.click_tally + 2'd1;
               btn.since_release = '0;
               if (btn.click_tally >= TALLY_DOUBLE) begin
                  gest.prev_press  = 1'b1;
                  btn.click_tally  = '0;
                  btn.next_pending = 1'b0;
               end else begin
                  btn.next_pending = 1'b1;
               end
            end
            gest.any_key  = 1'b1;
            btn.long_flag = 1'b0;
         end
      end
      gest.long_held      = btn.long_flag;
      gest.hold_indicator = btn.indicator_level;
      return gest;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         timing = '{DEBOUNCE_RST, SELECT_HOLD_RST, BACK_HOLD_RST, DOUBLE_CLICK_RST};
         btn    = STATE_RST;
         owed_gestures.delete();
      end else begin
         // response side first, so a stray beat never pairs with this edge's tick
         if (rsp_valid && rsp_ready) begin
            got = {rsp_next_press, rsp_prev_press, rsp_select_press, rsp_escape_press,
                   rsp_any_key, rsp_long_held, rsp_hold_indicator};
            if (owed_gestures.size() == 0) begin
               report_mismatch("response beat with none owed", int'(got), 0);
            end else begin
               want = owed_gestures.pop_front();
               if (got.next_press !== want.next_press)
                  report_mismatch("next_press", int'(got.next_press),
                                  int'(want.next_press));
               if (got.prev_press !== want.prev_press)
                  report_mismatch("prev_press", int'(got.prev_press),
                                  int'(want.prev_press));
               if (got.select_press !== want.select_press)
                  report_mismatch("select_press", int'(got.select_press),
                                  int'(want.select_press));
               if (got.escape_press !== want.escape_press)
                  report_mismatch("escape_press", int'(got.escape_press),
                                  int'(want.escape_press));
               if (got.any_key !== want.any_key)
                  report_mismatch("any_key", int'(got.any_key), int'(want.any_key));
               if (got.long_held !== want.long_held)
                  report_mismatch("long_held", int'(got.long_held), int'(want.long_held));
               if (got.hold_indicator !== want.hold_indicator)
                  report_mismatch("hold_indicator", int'(got.hold_indicator),
                                  int'(want.hold_indicator));
            end
         end
         if (req_valid && req_ready) owed_gestures.push_back(decode_tick(req_button_down));
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_DEBOUNCE:     timing.debounce_ms     = csr_wdata;
               CSR_SELECT_HOLD:  timing.select_hold_ms  = csr_wdata;
               CSR_BACK_HOLD:    timing.back_hold_ms    = csr_wdata;
               CSR_DOUBLE_CLICK: timing.double_click_ms = csr_wdata;
               default: ;
            endcase
         end
      end
      beats_owed <= owed_gestures.size();
   end

endmodule

/* verif/single_button_gesture_decoder_tb.sv */
// Testbench top for the gesture decoder: clock, reset, tick stimulus, timing writes, verdict.
`timescale 1ns / 100ps

module single_button_gesture_decoder_tb;
   import sbgd_pkg::*;

   // watchdog, well above the slowest legal run (every tick behind long gaps and stalls)
   localparam int LIMIT_CYCLES = 200_000;
   // longest hold or rest run that the gesture generator asks for
   localparam int RUN_CAP = 40;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_button_down = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_next_press;
   logic          rsp_prev_press;
   logic          rsp_select_press;
   logic          rsp_escape_press;
   logic          rsp_any_key;
   logic          rsp_long_held;
   logic [1:0]    rsp_hold_indicator;
   logic          csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_DEBOUNCE;
   logic [15:0]   csr_wdata = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int ticks_sent = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   // timing register values currently loaded, so the gestures can aim at the thresholds
   int cur_debounce = int'(DEBOUNCE_RST);
   int cur_select   = int'(SELECT_HOLD_RST);
   int cur_back     = int'(BACK_HOLD_RST);
   int cur_double   = int'(DOUBLE_CLICK_RST);

   single_button_gesture_decoder u_dut (.*);

   gesture_check u_check (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // idle length for either side: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clamp_len(input int n);
      if (n < 1) return 1;
      if (n > RUN_CAP) return RUN_CAP;
      return n;
   endfunction

   // receiver back-pressure, one nonblocking write of rsp_ready per falling edge
   always @(negedge clock) begin : rx_stall
      int n;
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         n = pick_gap();
         if (n == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = n - 1;
         end
      end
   end

   // one tick beat: optional idle gap, then hold valid until the edge that takes it
   task automatic send_tick(input logic level);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_button_down <= level;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   task automatic send_run(input logic level, input int n);
      repeat (n) send_tick(level);
   endtask

   // stop sending and wait until every owed gesture beat has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   // timing only changes with the decoder idle: nothing owed, no tick in flight
   task automatic set_timing(input logic [15:0] deb, input logic [15:0] sel,
                             input logic [15:0] bck, input logic [15:0] dbl);
      drain();
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_SELECT_HOLD, sel);
      write_reg(CSR_BACK_HOLD, bck);
      write_reg(CSR_DOUBLE_CLICK, dbl);
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      cur_debounce = int'(deb);
      cur_select   = int'(sel);
      cur_back     = int'(bck);
      cur_double   = int'(dbl);
   endtask

   // press held for a length aimed around the select/back thresholds, then a rest
   // aimed around the double-click window so second clicks land inside and outside it
   task automatic send_gesture();
      int hold;
      int rest;
      int hi;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            hi = cur_select - 1;
            if (hi < 1) hi = 1;
            hold = $urandom_range(1, hi);
         end
         4:       hold = cur_select + $urandom_range(0, 2) - 1;
         5, 6:    hold = $urandom_range(cur_select, cur_back);
         7:       hold = cur_back + $urandom_range(0, 2) - 1;
         default: hold = $urandom_range(1, cur_back + 3);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: rest = $urandom_range(1, cur_double + 1);
         4:          rest = cur_double + $urandom_range(0, 2);
         default:    rest = $urandom_range(cur_double + 2, cur_double + 8);
      endcase
      send_run(1'b1, clamp_len(hold));
      send_run(1'b0, clamp_len(rest));
   endtask

   // mostly well-formed gestures; the rest random levels, one-tick bounces and the odd drain
   task automatic random_phase(input int n);
      int start;
      int r;
      start = ticks_sent;
      while (ticks_sent - start < n) begin
         r = $urandom_range(0, 49);
         if (r < 40) begin
            send_gesture();
         end else if (r < 45) begin
            repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
         end else if (r < 49) begin
            send_tick(1'b1);
            send_tick(1'b0);
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // a few ticks on the reset timing: long debounce, counters start saturated
      repeat (12) send_tick(1'($urandom_range(0, 1)));

      // directed: no debounce, select at 3, back at 5, window of 2
      set_timing(16'd0, 16'd3, 16'd5, 16'd2);
      send_run(1'b0, 4);                         // let anything pending expire
      send_run(1'b1, 1); send_run(1'b0, 4);      // single click, next once window passes
      send_run(1'b1, 1); send_run(1'b0, 1);      // two clicks inside the window: previous
      send_run(1'b1, 1); send_run(1'b0, 2);
      send_run(1'b1, 4); send_run(1'b0, 1);      // held past select
      send_run(1'b1, 6); send_run(1'b0, 1);      // held past back: escape, indicator 2

      // all thresholds zero: every press is long and escape wins
      set_timing(16'd0, 16'd0, 16'd0, 16'd0);
      random_phase(60);

      // maximum debounce: after a press edge everything is swallowed
      set_timing(16'hFFFF, 16'd2, 16'd4, 16'd3);
      send_run(1'b1, 3);
      send_run(1'b0, 12);

      // holds and window never expire: only short clicks, tally never times out
      set_timing(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(60);

      // small random timings, back below select now and then, idling on or off per phase
      repeat (6) begin
         set_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 20)),
                    16'($urandom_range(0, 30)), 16'($urandom_range(0, 12)));
         idle_on = ($urandom_range(0, 3) != 0);
         random_phase(70);
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/sbgd_pkg.sv
rtl/core/sbgd_cfg.sv
rtl/core/sbgd_step.sv
rtl/core/single_button_gesture_decoder.sv
verif/gesture_check.sv
verif/single_button_gesture_decoder_tb.sv
